// ----- sv/fsmin_pkg.sv -----
// Fibonacci search minimizer: shared types, constants and codes.
// Used by fsmin_ctrl, fsmin_dp and fibonacci_search_minimizer_unit.
`default_nettype none
package fsmin_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COST_WIDTH_DEF = 32;
  localparam int LOOP_LIMIT     = 64;
  localparam int LOOP_CNT_W     = $clog2(LOOP_LIMIT);
  localparam int IDX_W          = 16;
  localparam int PC_W           = 7;
  localparam int OUT_IDX_W      = 6;
  localparam int IO_COST_W      = 32;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 48;

  localparam logic [PC_W-1:0] POINT_COUNT_RST = 7'd16;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_REPORT  = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    PH_WARMUP,
    PH_MAX,
    PH_LOOP,
    PH_LAST,
    PH_END
  } phase_t;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_FIB,
    ST_IDLE,
    ST_NARROW,
    ST_CLOSE,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic restart;
    logic fib_step;
    logic report;
    logic narrow_step;
    logic close;
    logic load_out;
  } fsmin_cmd_t;

  typedef struct packed {
    logic fib_more;
    logic phase_loop;
    logic narrow_probe;
    logic narrow_close;
    logic out_free;
  } fsmin_sts_t;

endpackage
`default_nettype wire

// ----- sv/fibonacci_search_minimizer_unit.sv -----
// Fibonacci search minimizer top level: stream ports, APB register, ctrl + datapath.
// Depends on fsmin_pkg, fsmin_ctrl and fsmin_dp.
// Each request gives exactly one result. A restart request (tuser 0) runs
// the Fibonacci bracket build and then loads its result. A cost report outside
// the search loop loads its result directly; in the search loop it first runs
// bracket-narrowing passes, then a closing step unless a pass needs a new probe;
// the narrowing pass of the datapath runs once a cycle. Requests are taken one
// at a time; a new request is accepted while the previous result waits in the
// output register. After reset the block rebuilds the bracket for 16 points,
// with in_tready low.
`default_nettype none
module fibonacci_search_minimizer_unit
  import fsmin_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COST_WIDTH = COST_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] cost
  input  wire logic                   in_tuser,   // [0] opcode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [5:0] next_index, [11:6] best_index,
                                                  // [43:12] best_cost, [47:44] zero
  output logic                        out_tuser,  // [0] search_done
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_AW-1:0]      paddr,
  input  wire logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]           prdata,
  output logic                        pready
);

  logic [PC_W-1:0] point_count_r;
  fsmin_cmd_t      cmd;
  fsmin_sts_t      sts;
  logic [OUT_IDX_W-1:0] nxt_idx, best_idx;
  logic [IO_COST_W-1:0] best_cost;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= POINT_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT)) begin
      point_count_r <= pwdata[PC_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POINT_COUNT) ? CFG_DW'(point_count_r) : '0;

  fsmin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsmin_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COST_WIDTH (COST_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .point_count     (point_count_r),
    .in_cost         (in_tdata),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_next_index  (nxt_idx),
    .out_search_done (out_tuser),
    .out_best_index  (best_idx),
    .out_best_cost   (best_cost)
  );

  assign out_tdata = {4'b0, best_cost, best_idx, nxt_idx};

endmodule
`default_nettype wire

// ----- sv/fsmin_ctrl.sv -----
// Fibonacci search minimizer: controller state machine and pass counter.
// Depends on fsmin_pkg; drives the command struct of fsmin_dp.
`default_nettype none
module fsmin_ctrl
  import fsmin_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_opcode,
  output logic            in_ready,
  input  wire fsmin_sts_t sts,
  output fsmin_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;
  logic boot_r;
  logic [LOOP_CNT_W-1:0] cnt_r;
  logic cnt_last;

  assign cnt_last = (cnt_r == LOOP_CNT_W'(LOOP_LIMIT - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_BOOT: state_nxt = ST_FIB;
      ST_FIB: begin
        if (!sts.fib_more) state_nxt = boot_r ? ST_IDLE : ST_EMIT;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_RESTART) state_nxt = ST_FIB;
          else if (sts.phase_loop) state_nxt = ST_NARROW;
          else state_nxt = ST_EMIT;
        end
      end
      ST_NARROW: begin
        if (sts.narrow_probe) state_nxt = ST_EMIT;
        else if (sts.narrow_close || cnt_last) state_nxt = ST_CLOSE;
      end
      ST_CLOSE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_BOOT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_BOOT:   cmd.restart = 1'b1;
      ST_FIB:    cmd.fib_step = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.restart = in_valid && (in_opcode == OP_RESTART);
        cmd.report  = in_valid && (in_opcode == OP_REPORT);
      end
      ST_NARROW: cmd.narrow_step = 1'b1;
      ST_CLOSE:  cmd.close = 1'b1;
      ST_EMIT:   cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
      boot_r  <= 1'b1;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIB && !sts.fib_more) boot_r <= 1'b0;
      if (state_r == ST_NARROW) cnt_r <= cnt_r + LOOP_CNT_W'(1);
      else cnt_r <= '0;
    end
  end

endmodule
`default_nettype wire

// ----- sv/fsmin_dp.sv -----
// Fibonacci search minimizer: bracket, probe slots, kept point and result register.
// Depends on fsmin_pkg; commanded by fsmin_ctrl.
`default_nettype none
module fsmin_dp
  import fsmin_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COST_WIDTH = COST_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fsmin_cmd_t            cmd,
  output fsmin_sts_t                 sts,
  input  wire logic [PC_W-1:0]       point_count,
  input  wire logic [IO_COST_W-1:0]  in_cost,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_IDX_W-1:0]       out_next_index,
  output logic                       out_search_done,
  output logic [OUT_IDX_W-1:0]       out_best_index,
  output logic [IO_COST_W-1:0]       out_best_cost
);

  localparam int SPW = $clog2(MAX_POINTS + 1);
  localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

  logic [SPW-1:0]        space_r;
  phase_t                phase_r;
  logic [IDX_W-1:0]      fib_high_r, fib_low_r, lower_r, upper_r, probe_r;
  logic                  slot_r;
  logic [IDX_W-1:0]      slot_idx_r [2];
  logic                  slot_vld_r [2];
  logic [COST_WIDTH-1:0] slot_cost_r [2];
  logic [IDX_W-1:0]      kept_idx_r;
  logic                  kept_vld_r;
  logic [COST_WIDTH-1:0] kept_cost_r, top_cost_r;
  logic                  out_valid_r;
  logic [OUT_IDX_W-1:0]  out_next_r, out_best_idx_r;
  logic                  out_done_r;
  logic [IO_COST_W-1:0]  out_best_cost_r;

  logic [SPW-1:0]        space_sat;
  logic [IDX_W-1:0]      last_pt, upper_min;
  logic [COST_WIDTH-1:0] cost_in;
  logic [IDX_W-1:0]      n_i0, n_raw1, n_i1, chk0, chk1;
  logic                  hit0, hit1, kh0, kh1, need0, need1, reuse0, reuse1;
  logic [COST_WIDTH-1:0] c0e, c1e, s0, s1;
  logic                  lt, lt_last, n_act, n_cmp;
  logic [IDX_W-1:0]      nl_v, nu_v, nu_min;
  logic                  end_sel;
  logic [IDX_W-1:0]      bi;
  logic [COST_WIDTH-1:0] bc;

  always_comb begin
    if (point_count < PC_W'(2)) space_sat = SPW'(2);
    else if (32'(point_count) > MAX_POINTS) space_sat = SPW'(MAX_POINTS);
    else space_sat = SPW'(point_count);
  end

  assign last_pt   = IDX_W'(space_r) - ONE;
  assign upper_min = (upper_r <= last_pt) ? upper_r : last_pt;
  assign cost_in   = COST_WIDTH'(in_cost);

  assign n_i0   = fib_low_r + lower_r - ONE;
  assign n_raw1 = fib_high_r + lower_r - ONE;
  assign n_i1   = (n_raw1 <= last_pt) ? n_raw1 : last_pt;
  assign n_act  = n_i0 < n_i1;

  assign chk0 = cmd.close ? lower_r : n_i0;
  assign chk1 = cmd.close ? upper_min : n_i1;

  assign hit0   = slot_vld_r[0] && (slot_idx_r[0] == chk0);
  assign hit1   = slot_vld_r[1] && (slot_idx_r[1] == chk1);
  assign kh0    = kept_vld_r && (kept_idx_r == chk0);
  assign kh1    = kept_vld_r && (kept_idx_r == chk1);
  assign need0  = !hit0 && !kh0;
  assign need1  = !hit1 && !kh1;
  assign reuse0 = !hit0 && kh0;
  assign reuse1 = !hit1 && kh1;
  assign c0e    = reuse0 ? kept_cost_r : slot_cost_r[0];
  assign c1e    = reuse1 ? kept_cost_r : slot_cost_r[1];
  assign lt     = c0e < c1e;

  // narrowing pass compares both slots only when neither needs a probe
  assign n_cmp  = n_act && !need0 && !need1;
  assign nl_v   = (n_cmp && !lt) ? n_i0 + ONE : lower_r;
  assign nu_v   = (n_cmp && lt) ? n_i1 - ONE : upper_r;
  assign nu_min = (nu_v <= last_pt) ? nu_v : last_pt;

  assign s0      = (slot_r == 1'b0) ? cost_in : slot_cost_r[0];
  assign s1      = (slot_r == 1'b1) ? cost_in : slot_cost_r[1];
  assign lt_last = s0 < s1;

  assign end_sel = kept_vld_r && !(top_cost_r < kept_cost_r);
  assign bi      = end_sel ? kept_idx_r : last_pt;
  assign bc      = end_sel ? kept_cost_r : top_cost_r;

  always_comb begin
    sts              = '0;
    sts.fib_more     = upper_r < IDX_W'(space_r);
    sts.phase_loop   = (phase_r == PH_LOOP);
    sts.narrow_probe = n_act && (need0 || need1);
    sts.narrow_close = !sts.narrow_probe &&
                       ({1'b0, nl_v} + (IDX_W+1)'(1) >= {1'b0, nu_min});
    sts.out_free     = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      space_r       <= space_sat;
      fib_high_r    <= ONE;
      fib_low_r     <= '0;
      lower_r       <= '0;
      upper_r       <= ONE;
      phase_r       <= PH_WARMUP;
      probe_r       <= IDX_W'(space_sat) - ONE;
      slot_r        <= 1'b0;
      slot_vld_r[0] <= 1'b0;
      slot_vld_r[1] <= 1'b0;
      kept_vld_r    <= 1'b0;
      kept_cost_r   <= '0;
      top_cost_r    <= '0;
    end else if (cmd.fib_step) begin
      if (sts.fib_more) begin
        fib_low_r  <= fib_high_r;
        fib_high_r <= upper_r;
        upper_r    <= fib_high_r + upper_r;
      end else begin
        upper_r <= upper_r - ONE;
      end
    end else if (cmd.report) begin
      case (phase_r)
        PH_WARMUP: begin
          top_cost_r <= '0;
          phase_r    <= PH_MAX;
        end
        PH_MAX: begin
          top_cost_r <= cost_in;
          probe_r    <= n_i0;
          slot_r     <= 1'b0;
          phase_r    <= PH_LOOP;
        end
        PH_LOOP: begin
          slot_cost_r[slot_r] <= cost_in;
          slot_idx_r[slot_r]  <= probe_r;
          slot_vld_r[slot_r]  <= 1'b1;
        end
        PH_LAST: begin
          slot_cost_r[slot_r] <= cost_in;
          slot_idx_r[slot_r]  <= probe_r;
          slot_vld_r[slot_r]  <= 1'b1;
          kept_vld_r          <= 1'b1;
          kept_idx_r          <= lt_last ? lower_r : upper_min;
          kept_cost_r         <= lt_last ? s0 : s1;
          phase_r             <= PH_END;
        end
        default: phase_r <= phase_r;
      endcase
    end else if (cmd.narrow_step) begin
      if (n_act) begin
        if (need0) begin
          probe_r <= n_i0;
          slot_r  <= 1'b0;
        end else begin
          if (reuse0) slot_cost_r[0] <= kept_cost_r;
          if (need1) begin
            probe_r <= n_i1;
            slot_r  <= 1'b1;
          end else begin
            if (reuse1) slot_cost_r[1] <= kept_cost_r;
            kept_vld_r  <= 1'b1;
            kept_idx_r  <= lt ? n_i0 : n_i1;
            kept_cost_r <= lt ? c0e : c1e;
            lower_r     <= nl_v;
            upper_r     <= nu_v;
          end
        end
      end
      if (!sts.narrow_probe) begin
        fib_high_r <= fib_low_r;
        fib_low_r  <= fib_high_r - fib_low_r;
      end
    end else if (cmd.close) begin
      if (reuse0) slot_cost_r[0] <= kept_cost_r;
      if (reuse1) slot_cost_r[1] <= kept_cost_r;
      if (need0) begin
        phase_r <= PH_LAST;
        probe_r <= chk0;
        slot_r  <= 1'b0;
      end else if (need1) begin
        phase_r <= PH_LAST;
        probe_r <= chk1;
        slot_r  <= 1'b1;
      end else begin
        phase_r <= PH_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (phase_r == PH_END) begin
        out_next_r      <= OUT_IDX_W'(bi);
        out_done_r      <= 1'b1;
        out_best_idx_r  <= OUT_IDX_W'(bi);
        out_best_cost_r <= IO_COST_W'(bc);
      end else begin
        out_next_r      <= OUT_IDX_W'(probe_r);
        out_done_r      <= 1'b0;
        out_best_idx_r  <= '0;
        out_best_cost_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_index  = out_next_r;
  assign out_search_done = out_done_r;
  assign out_best_index  = out_best_idx_r;
  assign out_best_cost   = out_best_cost_r;

endmodule
`default_nettype wire
